>>> src/vkd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vkd_pkg;
    localparam int FIELD_W          = 20;
    localparam int IDX_W            = 12;
    localparam int INDEX_LIMIT      = 4096;
    localparam int TABLE_DEPTH_DEF  = 4096;
    localparam int ATTR_BITS_DEF    = 20;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR_RD,
        ST_CLR_WR,
        ST_READ,
        ST_CMP
    } t_state;
endpackage
`default_nettype wire

>>> src/vkd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vkd_in_if;
    import vkd_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] pos_index;
    logic [FIELD_W-1:0] uv_index;
    logic [FIELD_W-1:0] norm_index;
    logic               start_new;
    modport source (output valid, pos_index, uv_index, norm_index, start_new, input ready);
    modport sink   (input valid, pos_index, uv_index, norm_index, start_new, output ready);
endinterface

interface vkd_out_if;
    import vkd_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] vert_idx;
    logic             is_new;
    logic             overflow;
    modport source (output valid, vert_idx, is_new, overflow, input ready);
    modport sink   (input valid, vert_idx, is_new, overflow, output ready);
endinterface
`default_nettype wire

>>> src/vertex_key_dedup_indexer.sv
`timescale 1ns / 1ps
`default_nettype none
// Face-corner deduplicator: each transaction carries a position/uv/normal index triple and
// returns its compact vertex index, flagged new on first sight or overflow (index 0) once the
// table holds min(TABLE_DEPTH, 4096) triples. Triples are hashed into a linear-probed table
// memory; each probe is a read state then a compare state, and the lookup engine takes no new
// corner until the previous result has been accepted. After reset the block clears every table
// entry before taking any corner; start_new first clears each slot in the list of occupied
// slots, with a log read and a table write per stored vertex.
// A two-entry queue decouples input acceptance from the lookup engine.
module vertex_key_dedup_indexer
    import vkd_pkg::*;
#(
    parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
    parameter int ATTR_INDEX_BITS = ATTR_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vkd_in_if.sink    i_in,
    vkd_out_if.source o_out
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = 3 * ATTR_INDEX_BITS;

    logic          w_q_valid, w_q_start, w_q_pop;
    logic [KW-1:0] w_q_key;
    logic [AW-1:0] w_q_hash;

    vkd_front #(.TABLE_DEPTH(TABLE_DEPTH), .ATTR_INDEX_BITS(ATTR_INDEX_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .o_q_key   (w_q_key),
        .o_q_start (w_q_start),
        .o_q_hash  (w_q_hash),
        .i_q_pop   (w_q_pop)
    );

    vkd_back #(.TABLE_DEPTH(TABLE_DEPTH), .ATTR_INDEX_BITS(ATTR_INDEX_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_key   (w_q_key),
        .i_q_start (w_q_start),
        .i_q_hash  (w_q_hash),
        .o_q_pop   (w_q_pop),
        .o_out     (o_out)
    );
endmodule
`default_nettype wire

>>> src/vkd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vkd_front
    import vkd_pkg::*;
#(
    parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
    parameter int ATTR_INDEX_BITS = ATTR_BITS_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int KW = 3 * ATTR_INDEX_BITS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    vkd_in_if.sink       i_in,
    output logic         o_q_valid,
    output logic [KW-1:0] o_q_key,
    output logic         o_q_start,
    output logic [AW-1:0] o_q_hash,
    input  wire logic    i_q_pop
);
    localparam int XW = FIELD_W + 1;

    logic [KW-1:0] r_key   [2];
    logic          r_start [2];
    logic [AW-1:0] r_hash  [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [KW-1:0] w_key;
    logic [AW-1:0] w_hash;
    logic          w_push;

    always_comb begin
        logic [XW-1:0] p, u, n;
        p = XW'(i_in.pos_index);
        u = XW'(i_in.uv_index);
        n = XW'(i_in.norm_index);
        w_key = {n[ATTR_INDEX_BITS-1:0], u[ATTR_INDEX_BITS-1:0], p[ATTR_INDEX_BITS-1:0]};
        w_hash = '0;
        for (int i = 0; i < KW; i++) begin
            w_hash[i % AW] = w_hash[i % AW] ^ w_key[i];
        end
        if ((AW+1)'(w_hash) >= (AW+1)'(TABLE_DEPTH)) w_hash = w_hash - AW'(TABLE_DEPTH);
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_key    = r_key[r_rp];
    assign o_q_start  = r_start[r_rp];
    assign o_q_hash   = r_hash[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_key[r_wp]   <= w_key;
            r_start[r_wp] <= i_in.start_new;
            r_hash[r_wp]  <= w_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule
`default_nettype wire

>>> src/vkd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module vkd_back
    import vkd_pkg::*;
#(
    parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
    parameter int ATTR_INDEX_BITS = ATTR_BITS_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int KW = 3 * ATTR_INDEX_BITS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_valid,
    input  wire logic [KW-1:0] i_q_key,
    input  wire logic     i_q_start,
    input  wire logic [AW-1:0] i_q_hash,
    output logic          o_q_pop,
    vkd_out_if.source     o_out
);
    localparam int CAP = (TABLE_DEPTH < INDEX_LIMIT) ? TABLE_DEPTH : INDEX_LIMIT;
    localparam int CW  = $clog2(CAP);
    localparam int NW  = IDX_W + 1;
    localparam int DW  = 1 + KW + IDX_W;

    logic [DW-1:0] tbl  [TABLE_DEPTH];
    logic [AW-1:0] slog [CAP];

    t_state        r_state, n_state;
    logic [KW-1:0] r_key;
    logic [AW-1:0] r_probe, n_probe;
    logic [AW:0]   r_count, n_count;
    logic [NW-1:0] r_next, n_next;
    logic [AW:0]   r_clr, n_clr;
    logic [DW-1:0] r_rd;
    logic [AW-1:0] r_log_q;
    logic          r_ov, n_ov;
    logic [IDX_W-1:0] r_oidx, n_oidx;
    logic          r_onew, n_onew, r_oovf, n_oovf;

    logic          w_take, w_hit, w_empty, w_full, w_last;
    logic          w_we, w_lwe;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;

    assign w_take  = (r_state == ST_IDLE) && i_q_valid && !r_ov;
    assign o_q_pop = w_take;
    assign w_hit   = r_rd[DW-1] && (r_rd[DW-2 -: KW] == r_key);
    assign w_empty = !r_rd[DW-1];
    assign w_full  = (r_next >= NW'(CAP));
    assign w_last  = (r_count == (AW+1)'(TABLE_DEPTH - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_clr == (AW+1)'(TABLE_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_take) n_state = (i_q_start && r_next != '0) ? ST_CLR_RD : ST_READ;
            end
            ST_CLR_RD: n_state = ST_CLR_WR;
            ST_CLR_WR: begin
                n_state = ((r_clr + 1'b1) == (AW+1)'(r_next)) ? ST_READ : ST_CLR_RD;
            end
            ST_READ: n_state = ST_CMP;
            ST_CMP: begin
                if (w_hit || w_empty || w_last) n_state = ST_IDLE;
                else n_state = ST_READ;
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        n_probe = r_probe;
        n_count = r_count;
        n_next  = r_next;
        n_clr   = r_clr;
        n_ov    = r_ov;
        n_oidx  = r_oidx;
        n_onew  = r_onew;
        n_oovf  = r_oovf;
        w_we    = 1'b0;
        w_lwe   = 1'b0;
        w_waddr = r_probe;
        w_wdata = {1'b1, r_key, r_next[IDX_W-1:0]};
        if (r_ov && o_out.ready) n_ov = 1'b0;
        case (r_state)
            ST_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_clr[AW-1:0];
                w_wdata = '0;
                n_clr   = r_clr + 1'b1;
                n_next  = '0;
            end
            ST_IDLE: begin
                n_probe = i_q_hash;
                n_count = '0;
                n_clr   = '0;
            end
            ST_CLR_WR: begin
                w_we    = 1'b1;
                w_waddr = r_log_q;
                w_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if ((r_clr + 1'b1) == (AW+1)'(r_next)) n_next = '0;
            end
            ST_CMP: begin
                if (w_hit) begin
                    n_ov = 1'b1; n_oidx = r_rd[IDX_W-1:0]; n_onew = 1'b0; n_oovf = 1'b0;
                end else if (w_empty && !w_full) begin
                    w_we   = 1'b1;
                    w_lwe  = 1'b1;
                    n_next = r_next + 1'b1;
                    n_ov = 1'b1; n_oidx = r_next[IDX_W-1:0]; n_onew = 1'b1; n_oovf = 1'b0;
                end else if (w_empty || w_last) begin
                    n_ov = 1'b1; n_oidx = '0; n_onew = 1'b0; n_oovf = 1'b1;
                end else begin
                    n_probe = (r_probe == AW'(TABLE_DEPTH - 1)) ? '0 : r_probe + 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) tbl[w_waddr] <= w_wdata;
        if (r_state == ST_READ) r_rd <= tbl[r_probe];
        if (w_lwe) slog[r_next[CW-1:0]] <= r_probe;
        if (r_state == ST_CLR_RD) r_log_q <= slog[r_clr[CW-1:0]];
        if (w_take) begin
            r_key   <= i_q_key;
        end
        r_probe <= n_probe;
        r_count <= n_count;
        r_oidx  <= n_oidx;
        r_onew  <= n_onew;
        r_oovf  <= n_oovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_next  <= '0;
            r_ov    <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_next  <= n_next;
            r_ov    <= n_ov;
            r_clr   <= n_clr;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.vert_idx     = r_oidx;
    assign o_out.is_new       = r_onew;
    assign o_out.overflow     = r_oovf;
endmodule
`default_nettype wire
